// ----- hw/rtl/odtc_pkg.sv -----
// Shared types, constants and coefficient ROM contents for the oil density
// temperature correction core. No dependencies.
package odtc_pkg;

   // Fixed-point scale of the quadratic coefficients
   localparam int COEF_FRAC_BITS = 40;

   // Field widths
   localparam int DENS_W = 18;
   localparam int TEMP_W = 16;
   localparam int OUT_W  = 19;

   // Temperature grid
   localparam int GRID_N        = 21;
   localparam int GRID_LAST     = 20;
   localparam int GRID_FALLBACK = 10;
   localparam int IDX_W         = 5;
   localparam int T_LOW         = -5000;
   localparam int T_HIGH        = 15000;
   localparam int T_STEP        = 1000;
   localparam int OFF_W         = 15;   // temperature - T_LOW, in range
   localparam int FRAC_W        = 10;
   localparam int WEIGHT_W      = 11;   // holds T_STEP itself

   // offset / T_STEP as ((offset >> 3) * RECIP_IDX) >> IDX_SHIFT, exact for offset < 2^15
   localparam int STEP_SHIFT = 3;
   localparam int IDX_SHIFT  = 19;
   localparam int IDX_PROD_W = 25;
   localparam logic [12:0] RECIP_IDX =
      13'(((1 << IDX_SHIFT) + (T_STEP / 8) - 1) / (T_STEP / 8));

   // Output saturation and floor(num / T_STEP) for 0 <= num < 2^29
   localparam int OUT_MAX     = 300000;
   localparam int SAT_NUM     = (OUT_MAX + 1) * T_STEP;
   localparam int NUM_Y_MSB   = 28;
   localparam int Y_W         = NUM_Y_MSB - STEP_SHIFT + 1;
   localparam int OUT_SHIFT   = 33;
   localparam int RECIP_OUT_W = 27;
   localparam int OUT_PROD_W  = Y_W + RECIP_OUT_W;
   localparam logic [RECIP_OUT_W-1:0] RECIP_OUT =
      RECIP_OUT_W'(((64'd1 << OUT_SHIFT) + 64'(T_STEP / 8) - 64'd1) / 64'(T_STEP / 8));

   // Datapath widths
   localparam int AW = COEF_FRAC_BITS + 2;     // a and b coefficients
   localparam int CW = COEF_FRAC_BITS + 17;    // c coefficient
   localparam int QW = COEF_FRAC_BITS + 3;     // a*d + b
   localparam int PW = QW + DENS_W + 1;        // (a*d + b) * d
   localparam int SW = PW + 1;                 // plus c and rounding half
   localparam int GW = 21;                     // grid value
   localparam int NW = 34;                     // interpolation numerator

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Classified item handed from front to back
   typedef struct packed {
      logic [DENS_W-1:0] density;
      logic [IDX_W-1:0]  idx_lo;
      logic [IDX_W-1:0]  idx_hi;
      logic [FRAC_W-1:0] frac;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } slot_type;

   // Raw decimal coefficients: a in 1e-11, b in 1e-8, c in 1e-4 (kg/m3)
   localparam int QUAD_A [GRID_N] = '{
      6429130, 5554160, 4642140, 3703530, 2956680, 1881570, 933093, 0,
      -1010560, -1806740, -2674700, -3516670, -4332780, -5119790, -5878470,
      -6608730, -7309350, -7983270, -8629530, -9008490, -9588980};
   localparam int QUAD_B [GRID_N] = '{
      83378703, 85623890, 87944813, 90324762, 92420167, 95065442, 97539572,
      100000000, 102600190, 104848410, 107222820, 109557480, 111851200,
      114096440, 116293320, 118440350, 120534010, 122578790, 124571820,
      126022690, 127864600};
   localparam int QUAD_C [GRID_N] = '{
      1426330, 1231950, 1033080, 830808, 638398, 422670, 211520, 0,
      -218031, -422355, -632402, -841279, -1048850, -1254690, -1458720,
      -1660800, -1860700, -2058560, -2254190, -2422210, -2609330};

   localparam logic [63:0] DEN_A = 64'd10000000000000;
   localparam logic [63:0] DEN_B = 64'd100000000;
   localparam logic [63:0] DEN_C = 64'd100;

   typedef logic signed [CW-1:0] coef_tab_type [GRID_N];

   // round(m * 2^F / den), half away from zero; elaboration only
   function automatic logic signed [CW-1:0] to_fixed(input int m, input logic [63:0] den);
      logic        neg;
      logic [63:0] mag;
      logic [127:0] num;
      logic [127:0] quo;
      logic [63:0] rem;
      neg = (m < 0);
      mag = neg ? 64'(-longint'(m)) : 64'(m);
      num = {64'd0, mag} << COEF_FRAC_BITS;
      quo = '0;
      rem = '0;
      for (int i = 127; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      if ({rem[62:0], 1'b0} >= den) begin
         quo = quo + 128'd1;
      end
      return neg ? -(CW'(quo)) : CW'(quo);
   endfunction

   function automatic coef_tab_type build_tab_a();
      coef_tab_type t;
      for (int i = 0; i < GRID_N; i++) begin
         t[i] = to_fixed(QUAD_A[i], DEN_A);
      end
      return t;
   endfunction

   function automatic coef_tab_type build_tab_b();
      coef_tab_type t;
      for (int i = 0; i < GRID_N; i++) begin
         t[i] = to_fixed(QUAD_B[i], DEN_B);
      end
      return t;
   endfunction

   function automatic coef_tab_type build_tab_c();
      coef_tab_type t;
      for (int i = 0; i < GRID_N; i++) begin
         t[i] = to_fixed(QUAD_C[i], DEN_C);
      end
      return t;
   endfunction

   localparam coef_tab_type COEF_A = build_tab_a();
   localparam coef_tab_type COEF_B = build_tab_b();
   localparam coef_tab_type COEF_C = build_tab_c();

endpackage

// ----- hw/rtl/odtc_front.sv -----
// Front end: takes items on the request port, picks grid points and weight.
// Depends on odtc_pkg.
module odtc_front import odtc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [DENS_W-1:0]        req_density_in,
   input  logic signed [TEMP_W-1:0] req_temperature,
   input  logic                     queue_full,
   output slot_type                 push_slot
);

   logic              valid_ff, valid_in;
   item_type          item_ff, item_in;
   logic              accept, push;
   logic              in_range;
   logic signed [TEMP_W:0] temp_ext, off_full;
   logic [OFF_W-1:0]  off;
   logic [IDX_PROD_W-1:0] idx_prod;
   logic [IDX_W-1:0]  idx_div;
   logic [OFF_W-1:0]  frac_full;

   assign push   = valid_ff && !queue_full;
   assign busy   = reset || (valid_ff && queue_full);
   assign accept = start && !busy;

   always_comb begin
      temp_ext  = {req_temperature[TEMP_W-1], req_temperature};
      off_full  = temp_ext - (TEMP_W+1)'(T_LOW);
      in_range  = (req_temperature >= T_LOW) && (req_temperature <= T_HIGH);
      off       = off_full[OFF_W-1:0];
      // divide by the grid step: shift out the factor 8, reciprocal for 125
      idx_prod  = IDX_PROD_W'(off[OFF_W-1:STEP_SHIFT]) * IDX_PROD_W'(RECIP_IDX);
      idx_div   = idx_prod[IDX_SHIFT +: IDX_W];
      frac_full = off - OFF_W'(idx_div * T_STEP);

      item_in.density = req_density_in;
      if (in_range) begin
         item_in.idx_lo = idx_div;
         item_in.idx_hi = (idx_div == IDX_W'(GRID_LAST)) ? idx_div : idx_div + IDX_W'(1);
         item_in.frac   = frac_full[FRAC_W-1:0];
      end else begin
         // out of the grid: 50 C point alone
         item_in.idx_lo = IDX_W'(GRID_FALLBACK);
         item_in.idx_hi = IDX_W'(GRID_FALLBACK);
         item_in.frac   = '0;
      end

      valid_in = accept ? 1'b1 : (push ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign push_slot.valid = push;
   assign push_slot.item  = item_ff;

endmodule

// ----- hw/rtl/odtc_queue.sv -----
// Two-entry queue between front and back end; pops whenever non-empty.
// Depends on odtc_pkg.
module odtc_queue import odtc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  slot_type push_slot,
   output logic     full,
   output slot_type pop_slot
);

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push = push_slot.valid && !full;
   // back end never stalls
   assign do_pop  = (count_ff != '0);

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_slot.item;
      end
   end

   assign pop_slot.valid = do_pop;
   assign pop_slot.item  = mem_ff[rd_ptr_ff];

endmodule

// ----- hw/rtl/odtc_back.sv -----
// Back end: six-stage pipeline, quadratic at two grid points, interpolation,
// saturation. Depends on odtc_pkg.
module odtc_back import odtc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  slot_type         pop_slot,
   output logic             rsp_valid,
   output logic [OUT_W-1:0] rsp_density_out
);

   localparam int STAGES = 6;
   localparam logic signed [SW-1:0] ROUND_HALF =
      {{(SW-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

   logic [STAGES-1:0] valid_ff, valid_in;

   // stage 1: coefficient ROM
   logic signed [AW-1:0] a_ff [2], a_in [2];
   logic signed [AW-1:0] b_ff [2], b_in [2];
   logic signed [CW-1:0] c1_ff [2], c1_in [2];
   logic [DENS_W-1:0]    d1_ff;
   logic [FRAC_W-1:0]    frac1_ff;
   // stage 2: a*d + b
   logic signed [AW+DENS_W:0] ad_sum [2];
   logic signed [QW-1:0] q_ff [2], q_in [2];
   logic signed [CW-1:0] c2_ff [2];
   logic [DENS_W-1:0]    d2_ff;
   logic [FRAC_W-1:0]    frac2_ff;
   // stage 3: (a*d + b) * d
   logic signed [PW-1:0] p_ff [2], p_in [2];
   logic signed [CW-1:0] c3_ff [2];
   logic [FRAC_W-1:0]    frac3_ff;
   // stage 4: add c, round, scale down
   logic signed [SW-1:0] s4_sum [2], s4_shift [2];
   logic signed [GW-1:0] g_ff [2], g_in [2];
   logic [FRAC_W-1:0]    frac4_ff;
   // stage 5: interpolation numerator
   logic [WEIGHT_W-1:0]  w_lo, w_hi;
   logic signed [NW-1:0] t_lo, t_hi;
   logic signed [NW-1:0] num_ff, num_in;
   // stage 6: divide by step, saturate
   logic [Y_W-1:0]        y;
   logic [OUT_PROD_W-1:0] qprod;
   logic [OUT_W-1:0]      out_ff, out_in;

   assign valid_in = {valid_ff[STAGES-2:0], pop_slot.valid};

   always_comb begin
      a_in[0]  = COEF_A[pop_slot.item.idx_lo][AW-1:0];
      a_in[1]  = COEF_A[pop_slot.item.idx_hi][AW-1:0];
      b_in[0]  = COEF_B[pop_slot.item.idx_lo][AW-1:0];
      b_in[1]  = COEF_B[pop_slot.item.idx_hi][AW-1:0];
      c1_in[0] = COEF_C[pop_slot.item.idx_lo];
      c1_in[1] = COEF_C[pop_slot.item.idx_hi];

      for (int l = 0; l < 2; l++) begin
         ad_sum[l]   = a_ff[l] * $signed({1'b0, d1_ff}) + (AW+DENS_W+1)'(b_ff[l]);
         q_in[l]     = ad_sum[l][QW-1:0];
         p_in[l]     = q_ff[l] * $signed({1'b0, d2_ff});
         s4_sum[l]   = SW'(p_ff[l]) + SW'(c3_ff[l]) + ROUND_HALF;
         s4_shift[l] = s4_sum[l] >>> COEF_FRAC_BITS;
         g_in[l]     = s4_shift[l][GW-1:0];
      end

      w_hi   = WEIGHT_W'(frac4_ff);
      w_lo   = WEIGHT_W'(T_STEP) - w_hi;
      t_lo   = NW'(g_ff[0]) * NW'($signed({1'b0, w_lo}));
      t_hi   = NW'(g_ff[1]) * NW'($signed({1'b0, w_hi}));
      num_in = t_lo + t_hi + NW'(T_STEP / 2);

      // floor(num / 1000) = floor((num >> 3) / 125), valid below the clamp
      y     = num_ff[NUM_Y_MSB:STEP_SHIFT];
      qprod = OUT_PROD_W'(y) * OUT_PROD_W'(RECIP_OUT);
      if (num_ff < 0) begin
         out_in = '0;
      end else if (num_ff >= NW'(SAT_NUM)) begin
         out_in = OUT_W'(OUT_MAX);
      end else begin
         out_in = qprod[OUT_SHIFT +: OUT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         a_ff[l]  <= a_in[l];
         b_ff[l]  <= b_in[l];
         c1_ff[l] <= c1_in[l];
         q_ff[l]  <= q_in[l];
         c2_ff[l] <= c1_ff[l];
         p_ff[l]  <= p_in[l];
         c3_ff[l] <= c2_ff[l];
         g_ff[l]  <= g_in[l];
      end
      d1_ff    <= pop_slot.item.density;
      frac1_ff <= pop_slot.item.frac;
      d2_ff    <= d1_ff;
      frac2_ff <= frac1_ff;
      frac3_ff <= frac2_ff;
      frac4_ff <= frac3_ff;
      num_ff   <= num_in;
      out_ff   <= out_in;
   end

   assign rsp_valid       = valid_ff[STAGES-1];
   assign rsp_density_out = out_ff;

endmodule

// ----- hw/rtl/oil_density_temp_correction_core.sv -----
// Top level of the oil density temperature correction core.
// Depends on odtc_pkg, odtc_front, odtc_queue, odtc_back.

// Converts a density at 20 C (0.01 kg/m3) and a working temperature
// (0.01 C, signed) into the density at that temperature, from a quadratic
// per 10 C grid point (-50..150 C) and linear interpolation between the two
// neighboring points; temperatures outside the grid use the 50 C point.
// Results saturate to 0..300000. One item per clock is accepted (start high
// while busy is low). Its result is driven for one cycle with rsp_valid high
// after passing one front register, one queue slot and six back-end stages.
// Results cannot be held off. The rate is set by the back-end pipeline, which
// takes one item every clock with at most one multiplier per stage per lane.
// A two-entry queue sits between the classifying front end and the back end;
// since the back end drains it every cycle, busy is high only during reset.
// No clearing pass after reset.
module oil_density_temp_correction_core import odtc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [DENS_W-1:0]        req_density_in,
   input  logic signed [TEMP_W-1:0] req_temperature,
   output logic                     rsp_valid,
   output logic [OUT_W-1:0]         rsp_density_out
);

   // accept edge to the edge that takes the result
   localparam int RSP_LATENCY = 8;

   slot_type push_slot;   // front -> queue
   slot_type pop_slot;    // queue -> back
   logic     queue_full;

   // front: grid index pair and interpolation weight
   odtc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_density_in  (req_density_in),
      .req_temperature (req_temperature),
      .queue_full      (queue_full),
      .push_slot       (push_slot)
   );

   // decoupling queue
   odtc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_slot (push_slot),
      .full      (queue_full),
      .pop_slot  (pop_slot)
   );

   // back: coefficient lookup, two quadratics, interpolation, saturation
   odtc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_slot        (pop_slot),
      .rsp_valid       (rsp_valid),
      .rsp_density_out (rsp_density_out)
   );

   // every accepted item yields its result after the fixed latency
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##RSP_LATENCY rsp_valid)
      else $error("accepted item produced no result on time");

   // no result without an item accepted the fixed latency earlier
   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, RSP_LATENCY))
      else $error("result without matching accepted item");

   // saturation bound
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_density_out <= OUT_W'(OUT_MAX)))
      else $error("result above saturation limit");

   // back end never stalls, so the queue never fills
   a_no_backpressure: assert property (@(posedge clock) disable iff (reset)
      !queue_full)
      else $error("decoupling queue filled up");

endmodule

// ----- dv/tb_oil_density_temp_correction_core.sv -----
// Testbench for oil_density_temp_correction_core: directed edge items, then bursty random
// traffic, with every result checked against an in-bench density correction predictor.
// Depends on odtc_pkg and the core RTL.
module tb_oil_density_temp_correction_core;
   import odtc_pkg::*;

   localparam int FIX_BITS    = 40;      // coefficient scale, 2^-40
   localparam int GRID_TOP    = 20;
   localparam int GRID_MID    = 10;      // 50 C point, used off the grid
   localparam int TEMP_MIN    = -5000;
   localparam int TEMP_MAX    = 15000;
   localparam int TEMP_STEP   = 1000;
   localparam int DENS_SAT    = 300000;
   localparam int RAND_ITEMS  = 1250;
   localparam int DRAIN_WAIT  = 24;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic [DENS_W-1:0]        density;
      logic signed [TEMP_W-1:0] temp;
      logic [OUT_W-1:0]         density_out;
   } corrected_type;

   // Decimal table: a in 1e-11, b in 1e-8, c in 1e-4 (kg/m3)
   int raw_a [21] = '{
      6429130, 5554160, 4642140, 3703530, 2956680, 1881570, 933093, 0,
      -1010560, -1806740, -2674700, -3516670, -4332780, -5119790, -5878470,
      -6608730, -7309350, -7983270, -8629530, -9008490, -9588980};
   int raw_b [21] = '{
      83378703, 85623890, 87944813, 90324762, 92420167, 95065442, 97539572,
      100000000, 102600190, 104848410, 107222820, 109557480, 111851200,
      114096440, 116293320, 118440350, 120534010, 122578790, 124571820,
      126022690, 127864600};
   int raw_c [21] = '{
      1426330, 1231950, 1033080, 830808, 638398, 422670, 211520, 0,
      -218031, -422355, -632402, -841279, -1048850, -1254690, -1458720,
      -1660800, -1860700, -2058560, -2254190, -2422210, -2609330};

   longint quad_fix_a [21];
   longint quad_fix_b [21];
   longint quad_fix_c [21];

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [DENS_W-1:0]        req_density_in = '0;
   logic signed [TEMP_W-1:0] req_temperature = '0;
   logic                     rsp_valid;
   logic [OUT_W-1:0]         rsp_density_out;

   corrected_type pending_densities [$];

   int items_sent    = 0;
   int results_seen  = 0;
   int mismatches    = 0;
   int off_grid_cnt  = 0;
   int zero_sat_cnt  = 0;
   int cycle_cnt     = 0;
   int burst_left    = 0;

   oil_density_temp_correction_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_density_in  (req_density_in),
      .req_temperature (req_temperature),
      .rsp_valid       (rsp_valid),
      .rsp_density_out (rsp_density_out)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Density correction predictor
   // ---------------------------------------------------------------------

   // round(m * 2^40 / den), half away from zero
   function automatic longint scale_coef(input int m, input longint unsigned den);
      logic        neg;
      longint      mag;
      logic [127:0] num;
      logic [127:0] quo;
      logic [127:0] rem;
      neg = (m < 0);
      mag = neg ? -longint'(m) : longint'(m);
      num = 128'(mag) << FIX_BITS;
      quo = num / 128'(den);
      rem = num % 128'(den);
      if ((rem << 1) >= 128'(den)) begin
         quo = quo + 128'd1;
      end
      return neg ? -longint'(quo) : longint'(quo);
   endfunction

   // Quadratic at one grid point, rounded to nearest (half up) back to 0.01 kg/m3
   function automatic longint grid_density(input int idx, input logic [DENS_W-1:0] d);
      logic signed [127:0] dd;
      logic signed [127:0] acc;
      dd  = $signed({110'd0, d});
      acc = 128'(quad_fix_a[idx]) * dd * dd + 128'(quad_fix_b[idx]) * dd
            + 128'(quad_fix_c[idx]) + (128'sd1 <<< (FIX_BITS - 1));
      return longint'(acc >>> FIX_BITS);
   endfunction

   function automatic logic [OUT_W-1:0] clamp_density(input longint v);
      if (v < 0) begin
         return '0;
      end
      if (v > DENS_SAT) begin
         return OUT_W'(DENS_SAT);
      end
      return OUT_W'(v);
   endfunction

   function automatic logic [OUT_W-1:0] corrected_density(input logic [DENS_W-1:0] d,
                                                          input logic signed [TEMP_W-1:0] t);
      int     temp_i;
      int     offs;
      int     lo_idx;
      int     hi_idx;
      int     frac;
      longint num;
      temp_i = int'(t);
      // off the grid: 50 C point alone
      if (temp_i < TEMP_MIN || temp_i > TEMP_MAX) begin
         return clamp_density(grid_density(GRID_MID, d));
      end
      offs   = temp_i - TEMP_MIN;
      lo_idx = offs / TEMP_STEP;
      frac   = offs % TEMP_STEP;
      hi_idx = (lo_idx < GRID_TOP) ? lo_idx + 1 : GRID_TOP;
      num    = grid_density(lo_idx, d) * (TEMP_STEP - frac)
               + grid_density(hi_idx, d) * frac + TEMP_STEP / 2;
      // floor(num/1000) is negative exactly when num is
      if (num < 0) begin
         return '0;
      end
      return clamp_density(num / TEMP_STEP);
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Hold the item until the core takes it; record the expected density at that edge.
   task automatic send_item(input logic [DENS_W-1:0] d, input logic signed [TEMP_W-1:0] t);
      corrected_type exp_item;
      start           <= 1'b1;
      req_density_in  <= d;
      req_temperature <= t;
      do begin
         @(posedge clock);
      end while (busy);
      exp_item.density     = d;
      exp_item.temp        = t;
      exp_item.density_out = corrected_density(d, t);
      pending_densities.push_back(exp_item);
      items_sent++;
      if (int'(t) < TEMP_MIN || int'(t) > TEMP_MAX) begin
         off_grid_cnt++;
      end
      if (exp_item.density_out == '0) begin
         zero_sat_cnt++;
      end
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_densities.size() != 0) @(posedge clock);
   endtask

   // Bursts of random length, random gaps between them; some bursts run long with no gap.
   task automatic paced_send(input logic [DENS_W-1:0] d, input logic signed [TEMP_W-1:0] t);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            idle_cycles(gap);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 24);
      end
      send_item(d, t);
      burst_left--;
   endtask

   // Grid and fallback edges at a typical crude density
   task automatic test_temperature_edges();
      send_item(18'd86000, -16'sd5000);       // bottom grid point
      send_item(18'd86000, -16'sd5001);       // just below the grid
      send_item(18'd86000, 16'sd15000);       // top point, upper index clamped
      send_item(18'd86000, 16'sd15001);       // just above the grid
      send_item(18'd86000, 16'sd14999);
      send_item(18'd86000, 16'sd14001);
      send_item(18'd86000, -16'sd32768);
      send_item(18'd86000, 16'sd32767);
      send_item(18'd86000, 16'sd0);
      send_item(18'd86000, 16'sd2000);        // reference temperature
      send_item(18'd86000, -16'sd1);
      send_item(18'd86000, -16'sd2345);       // negative, interpolated
      send_item(18'd86000, 16'sd4999);
   endtask

   // Density extremes, including values past the nominal 200000
   task automatic test_density_extremes();
      send_item(18'd0, -16'sd5000);
      send_item(18'd0, 16'sd15000);           // negative grid value, clamps to zero
      send_item(18'd0, 16'sd7777);
      send_item(18'h3FFFF, -16'sd5000);
      send_item(18'h3FFFF, 16'sd15000);
      send_item(18'h3FFFF, -16'sd32768);
      send_item(18'd200000, -16'sd4321);
      send_item(18'd200000, 16'sd32767);
      send_item(18'd1, 16'sd12345);
      send_item(18'h2AAAA, 16'sh5555);
      send_item(18'h15555, -16'sd21846);
   endtask

   task automatic random_item(output logic [DENS_W-1:0] d, output logic signed [TEMP_W-1:0] t);
      int mode;
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
         t = TEMP_W'(int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN);
      end else if (mode == 6) begin
         case ($urandom_range(0, 1))
            0: t = TEMP_W'(TEMP_MIN + int'($urandom_range(0, 6)) - 3);
            default: t = TEMP_W'(TEMP_MAX + int'($urandom_range(0, 6)) - 3);
         endcase
      end else begin
         t = TEMP_W'($urandom());
      end
      if ($urandom_range(0, 9) < 7) begin
         d = DENS_W'($urandom_range(60000, 110000));
      end else begin
         d = DENS_W'($urandom());
      end
   endtask

   task automatic test_random_traffic(input int n);
      logic [DENS_W-1:0]        d;
      logic signed [TEMP_W-1:0] t;
      repeat (n) begin
         random_item(d, t);
         paced_send(d, t);
      end
   endtask

   // Sender holds off until every outstanding result is back, then resumes
   task automatic test_drain_pause();
      idle_cycles(1);
      wait_drained();
      send_item(18'd90000, 16'sd3500);
      send_item(18'd90000, -16'sd3500);
   endtask

   // ---------------------------------------------------------------------
   // Result checking: results cannot be stalled, so every strobe is taken
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      corrected_type exp_item;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_densities.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got density_out %0d",
                     $time, rsp_density_out);
         end else begin
            exp_item = pending_densities.pop_front();
            if (rsp_density_out !== exp_item.density_out) begin
               mismatches++;
               $display("%0t: density_in %0d temp %0d: expected density_out %0d, got %0d",
                        $time, exp_item.density, exp_item.temp,
                        exp_item.density_out, rsp_density_out);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_densities.size());
         $display("tb_oil_density_temp_correction_core failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i <= GRID_TOP; i++) begin
         quad_fix_a[i] = scale_coef(raw_a[i], 64'd10000000000000);
         quad_fix_b[i] = scale_coef(raw_b[i], 64'd100000000);
         quad_fix_c[i] = scale_coef(raw_c[i], 64'd100);
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_temperature_edges();
      test_density_extremes();
      test_random_traffic(RAND_ITEMS / 2);
      test_drain_pause();
      test_random_traffic(RAND_ITEMS - RAND_ITEMS / 2);

      idle_cycles(1);
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d items (%0d off the grid, %0d expected at zero clamp).",
               items_sent, off_grid_cnt, zero_sat_cnt);
      $display("Checked %0d results, %0d mismatches.", results_seen, mismatches);
      if (mismatches == 0 && pending_densities.size() == 0) begin
         $display("tb_oil_density_temp_correction_core passed");
      end else begin
         $display("tb_oil_density_temp_correction_core failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/odtc_pkg.sv
hw/rtl/odtc_front.sv
hw/rtl/odtc_queue.sv
hw/rtl/odtc_back.sv
hw/rtl/oil_density_temp_correction_core.sv
dv/tb_oil_density_temp_correction_core.sv
